/* rtl/fqp_pkg.sv */
// shared types and constants for the fastq record parser
package fqp_pkg;

   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   localparam logic [1:0] LINE_HEADER = 2'd0;
   localparam logic [1:0] LINE_SEQ    = 2'd1;
   localparam logic [1:0] LINE_SEP    = 2'd2;
   localparam logic [1:0] LINE_QUAL   = 2'd3;

   localparam logic [1:0] FIELD_NAME = 2'd0;
   localparam logic [1:0] FIELD_SEQ  = 2'd1;
   localparam logic [1:0] FIELD_QUAL = 2'd2;

   localparam logic [1:0] ERR_NONE          = 2'd0;
   localparam logic [1:0] ERR_BAD_HEADER    = 2'd1;
   localparam logic [1:0] ERR_BAD_SEPARATOR = 2'd2;
   localparam logic [1:0] ERR_TRUNCATED     = 2'd3;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_EOS  = 1'b1;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       byte_valid;
      logic [1:0] field_code;
      logic       record_done;
      logic       stream_done;
      logic [1:0] error_code;
   } result_type;

   // all results caused by one input item
   typedef struct packed {
      result_type first;
      result_type second;
      logic [1:0] count;
   } run_type;

   typedef struct packed {
      logic [1:0] line_index;
      logic       line_started;
      logic       char_seen;
      logic       cr_pending;
      logic       name_open;
      logic       halted;
   } parse_state_type;

endpackage

/* rtl/fqp_front.sv */
// front end: accepts bytes, tracks the record lines and builds result runs
module fqp_front
   import fqp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       kind,
   input  logic [7:0] data_byte,
   output logic       push,
   output run_type    run
);

   parse_state_type state_ff, state_in;
   run_type         run_c;

   function automatic run_type add_result(run_type r, result_type x);
      run_type o;
      o = r;
      if (r.count == 2'd0) begin
         o.first = x;
      end else begin
         o.second = x;
      end
      o.count = r.count + 2'd1;
      return o;
   endfunction

   function automatic result_type flag_result(logic rec, logic strm, logic [1:0] err);
      result_type x;
      x = '0;
      x.record_done = rec;
      x.stream_done = strm;
      x.error_code  = err;
      return x;
   endfunction

   function automatic result_type byte_result(logic [7:0] b, logic [1:0] field);
      result_type x;
      x = '0;
      x.byte_value = b;
      x.byte_valid = 1'b1;
      x.field_code = field;
      return x;
   endfunction

   // one kept byte: updates the line state and maybe adds a result
   task automatic kept_step(inout parse_state_type s, inout run_type r, input logic [7:0] b);
      unique case (s.line_index)
         LINE_HEADER: begin
            if (!s.char_seen) begin
               s.char_seen = 1'b1;
               if (b != CH_AT) begin
                  r = add_result(r, flag_result(1'b0, 1'b0, ERR_BAD_HEADER));
                  s.halted = 1'b1;
               end
            end else if (s.name_open) begin
               if (b == CH_SPACE) begin
                  s.name_open = 1'b0;
               end else begin
                  r = add_result(r, byte_result(b, FIELD_NAME));
               end
            end
         end
         LINE_SEQ: begin
            s.char_seen = 1'b1;
            r = add_result(r, byte_result(b, FIELD_SEQ));
         end
         LINE_SEP: begin
            if (!s.char_seen) begin
               s.char_seen = 1'b1;
               if (b != CH_PLUS) begin
                  r = add_result(r, flag_result(1'b0, 1'b0, ERR_BAD_SEPARATOR));
                  s.halted = 1'b1;
               end
            end
         end
         LINE_QUAL: begin
            s.char_seen = 1'b1;
            r = add_result(r, byte_result(b, FIELD_QUAL));
         end
         default: begin
         end
      endcase
   endtask

   always_comb begin
      parse_state_type s;
      run_type         r;
      s = state_ff;
      r = '0;
      if (!s.halted) begin
         if (kind == KIND_EOS) begin
            s.cr_pending = 1'b0;
            s.halted     = 1'b1;
            if (s.line_index == LINE_HEADER && !s.line_started) begin
               r = add_result(r, flag_result(1'b0, 1'b1, ERR_NONE));
            end else if (s.line_index == LINE_QUAL && s.line_started) begin
               r = add_result(r, flag_result(1'b1, 1'b0, ERR_NONE));
               r = add_result(r, flag_result(1'b0, 1'b1, ERR_NONE));
            end else begin
               r = add_result(r, flag_result(1'b0, 1'b0, ERR_TRUNCATED));
            end
         end else if (data_byte == CH_LF) begin
            s.cr_pending = 1'b0;
            if (s.line_index == LINE_HEADER && !s.char_seen) begin
               r = add_result(r, flag_result(1'b0, 1'b0, ERR_BAD_HEADER));
               s.halted = 1'b1;
            end else if (s.line_index == LINE_SEP && !s.char_seen) begin
               r = add_result(r, flag_result(1'b0, 1'b0, ERR_BAD_SEPARATOR));
               s.halted = 1'b1;
            end else begin
               if (s.line_index == LINE_QUAL) begin
                  r = add_result(r, flag_result(1'b1, 1'b0, ERR_NONE));
                  s.line_index = LINE_HEADER;
                  s.name_open  = 1'b1;
               end else begin
                  s.line_index = s.line_index + 2'd1;
               end
               s.char_seen    = 1'b0;
               s.line_started = 1'b0;
            end
         end else begin
            s.line_started = 1'b1;
            // a held cr not followed by lf is an ordinary byte
            if (s.cr_pending) begin
               s.cr_pending = 1'b0;
               kept_step(s, r, CH_CR);
            end
            if (!s.halted) begin
               if (data_byte == CH_CR) begin
                  s.cr_pending = 1'b1;
               end else begin
                  kept_step(s, r, data_byte);
               end
            end
         end
      end
      state_in = s;
      run_c    = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{line_index: LINE_HEADER, line_started: 1'b0, char_seen: 1'b0,
                       cr_pending: 1'b0, name_open: 1'b1, halted: 1'b0};
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   assign push = accept && (run_c.count != 2'd0);
   assign run  = run_c;

endmodule

/* rtl/fqp_queue.sv */
// small fifo of result runs between the front and the back
module fqp_queue
   import fqp_pkg::*;
#(
   parameter int DEPTH
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  run_type        push_run,
   input  logic           pop,
   output logic           full,
   output logic           head_valid,
   output run_type        head_run
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   run_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_run   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_run;
      end
   end

endmodule

/* rtl/fqp_back.sv */
// back end: splits each run into single results in the output register
module fqp_back
   import fqp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  run_type    head_run,
   output logic       pop,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output result_type rsp_result,
   output logic       rsp_last
);

   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff, out_res_in;
   logic       out_last_ff, out_last_in;
   logic       second_ff, second_in;
   logic       load, is_last;

   assign load    = !out_valid_ff || rsp_ready;
   // last beat of the run: second half, or a run with a single result
   assign is_last = second_ff || (head_run.count == 2'd1);
   assign pop     = load && head_valid && is_last;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      out_last_in  = out_last_ff;
      second_in    = second_ff;
      if (load) begin
         out_valid_in = head_valid;
         if (head_valid) begin
            out_res_in  = second_ff ? head_run.second : head_run.first;
            out_last_in = is_last;
            second_in   = !is_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         second_ff    <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      out_res_ff  <= out_res_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_res_ff;
   assign rsp_last   = out_last_ff;

endmodule

/* rtl/fastq_record_parser.sv */
// top level of the fastq record parser
//
//   channel   ports   direction   beat
//   input     req_    in          one byte or end-of-stream mark
//   result    rsp_    out         one emitted byte or status flag
//
// One input beat is taken per cycle while the run queue has a free entry.
// An input beat yields zero, one or two result beats; the back end sends one
// result per cycle from its output register unless rsp_ready holds it back.
// A result passes from the queue entry into the output register, then out.
// Synchronous reset returns to the header line with an empty queue.
// A stalled result side fills the queue of QUEUE_DEPTH runs, then req_ready drops.
module fastq_record_parser
   import fqp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_byte_value,
   output logic       rsp_byte_valid,
   output logic [1:0] rsp_field_code,
   output logic       rsp_record_done,
   output logic       rsp_stream_done,
   output logic [1:0] rsp_error_code,
   output logic       rsp_last_of_run
);

   logic           accept;
   logic           push;
   run_type        push_run;
   run_type        head_run;
   logic           head_valid;
   logic           q_full;
   logic           q_pop;
   result_type     rsp_result;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   fqp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .kind      (req_kind),
      .data_byte (req_data_byte),
      .push      (push),
      .run       (push_run)
   );

   fqp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_run   (push_run),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_run   (head_run)
   );

   fqp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_run   (head_run),
      .pop        (q_pop),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result),
      .rsp_last   (rsp_last_of_run)
   );

   assign rsp_byte_value  = rsp_result.byte_value;
   assign rsp_byte_valid  = rsp_result.byte_valid;
   assign rsp_field_code  = rsp_result.field_code;
   assign rsp_record_done = rsp_result.record_done;
   assign rsp_stream_done = rsp_result.stream_done;
   assign rsp_error_code  = rsp_result.error_code;

endmodule

/* bench/fastq_record_parser_tb.sv */
// self-checking testbench for the fastq record parser
module fastq_record_parser_tb;
   import fqp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 660;
   localparam int LIMIT_CYCLES = 200000;
   localparam int BODY_ANY = 0;
   localparam int BODY_BASE = 1;
   localparam int BODY_QUAL = 2;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
   } feed_item_type;

   typedef struct packed {
      logic [7:0] value;
      logic       valid;
      logic [1:0] field;
      logic       rec_done;
      logic       strm_done;
      logic [1:0] err;
      logic       last;
   } out_beat_type;

   typedef enum int {
      END_CLEAN, END_IN_QUAL, END_TRUNCATED, END_BAD_HEADER,
      END_EMPTY_HEADER, END_BAD_SEPARATOR, END_EMPTY_SEPARATOR
   } stream_end_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_kind = KIND_DATA;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_byte_value;
   logic       rsp_byte_valid;
   logic [1:0] rsp_field_code;
   logic       rsp_record_done;
   logic       rsp_stream_done;
   logic [1:0] rsp_error_code;
   logic       rsp_last_of_run;

   feed_item_type  feed_q[$];
   feed_item_type  next_item;
   out_beat_type   expected_beats[$];
   out_beat_type   run_buf[2];
   out_beat_type   got;
   out_beat_type   want;
   int             run_n;
   int             send_idle = 38;
   int             recv_idle = 51;
   int             items_accepted = 0;
   int             total_items;
   int             mismatches = 0;
   int             beats_checked = 0;
   int             records_seen = 0;
   int             cycles = 0;
   stream_end_type end_kind;

   // parser state as seen by the predictor
   logic [1:0] cur_line = LINE_HEADER;
   logic       line_begun = 1'b0;
   logic       kept_seen = 1'b0;
   logic       cr_held = 1'b0;
   logic       in_name = 1'b1;
   logic       stopped = 1'b0;

   fastq_record_parser DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_byte_value(rsp_byte_value),
      .rsp_byte_valid(rsp_byte_valid),
      .rsp_field_code(rsp_field_code),
      .rsp_record_done(rsp_record_done),
      .rsp_stream_done(rsp_stream_done),
      .rsp_error_code(rsp_error_code),
      .rsp_last_of_run(rsp_last_of_run)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic void emit(logic [7:0] v, logic bv, logic [1:0] f, logic rd, logic sd,
                                logic [1:0] e);
      out_beat_type bt;
      bt.value = v;
      bt.valid = bv;
      bt.field = f;
      bt.rec_done = rd;
      bt.strm_done = sd;
      bt.err = e;
      bt.last = 1'b0;
      if (run_n < 2) begin
         run_buf[run_n] = bt;
         run_n++;
      end
   endfunction

   function automatic void raise_error(logic [1:0] code);
      emit(8'h00, 1'b0, FIELD_NAME, 1'b0, 1'b0, code);
      stopped = 1'b1;
   endfunction

   function automatic void take_kept(logic [7:0] b);
      case (cur_line)
         LINE_HEADER: begin
            if (!kept_seen) begin
               kept_seen = 1'b1;
               if (b != CH_AT) raise_error(ERR_BAD_HEADER);
            end else if (in_name) begin
               if (b == CH_SPACE) in_name = 1'b0;
               else emit(b, 1'b1, FIELD_NAME, 1'b0, 1'b0, ERR_NONE);
            end
         end
         LINE_SEQ: begin
            kept_seen = 1'b1;
            emit(b, 1'b1, FIELD_SEQ, 1'b0, 1'b0, ERR_NONE);
         end
         LINE_SEP: begin
            if (!kept_seen) begin
               kept_seen = 1'b1;
               if (b != CH_PLUS) raise_error(ERR_BAD_SEPARATOR);
            end
         end
         default: begin
            kept_seen = 1'b1;
            emit(b, 1'b1, FIELD_QUAL, 1'b0, 1'b0, ERR_NONE);
         end
      endcase
   endfunction

   function automatic void close_line();
      if (cur_line == LINE_HEADER && !kept_seen) begin
         raise_error(ERR_BAD_HEADER);
      end else if (cur_line == LINE_SEP && !kept_seen) begin
         raise_error(ERR_BAD_SEPARATOR);
      end else begin
         if (cur_line == LINE_QUAL) begin
            emit(8'h00, 1'b0, FIELD_NAME, 1'b1, 1'b0, ERR_NONE);
            cur_line = LINE_HEADER;
            in_name = 1'b1;
         end else begin
            cur_line = cur_line + 2'd1;
         end
         kept_seen = 1'b0;
         line_begun = 1'b0;
      end
   endfunction

   // work out the result beats of one accepted input beat
   function automatic void parse_step(logic kind, logic [7:0] b);
      run_n = 0;
      if (!stopped) begin
         if (kind == KIND_EOS) begin
            cr_held = 1'b0;
            if (cur_line == LINE_HEADER && !line_begun) begin
               emit(8'h00, 1'b0, FIELD_NAME, 1'b0, 1'b1, ERR_NONE);
               stopped = 1'b1;
            end else if (cur_line == LINE_QUAL && line_begun) begin
               emit(8'h00, 1'b0, FIELD_NAME, 1'b1, 1'b0, ERR_NONE);
               emit(8'h00, 1'b0, FIELD_NAME, 1'b0, 1'b1, ERR_NONE);
               stopped = 1'b1;
            end else begin
               raise_error(ERR_TRUNCATED);
            end
         end else if (b == CH_LF) begin
            cr_held = 1'b0;
            close_line();
         end else begin
            line_begun = 1'b1;
            // a held cr that is not followed by lf is an ordinary byte
            if (cr_held) begin
               cr_held = 1'b0;
               take_kept(CH_CR);
            end
            if (!stopped) begin
               if (b == CH_CR) cr_held = 1'b1;
               else take_kept(b);
            end
         end
      end
      for (int i = 0; i < run_n; i++) begin
         run_buf[i].last = (i == run_n - 1);
         expected_beats.push_back(run_buf[i]);
      end
   endfunction

   function automatic void feed(logic kind, logic [7:0] b);
      feed_item_type it;
      it.kind = kind;
      it.data = b;
      feed_q.push_back(it);
   endfunction

   function automatic logic [7:0] body_byte(int flavor);
      logic [7:0] b;
      if ($urandom_range(15) == 0) return CH_CR;
      case (flavor)
         BODY_BASE: begin
            case ($urandom_range(4))
               0: b = "A";
               1: b = "C";
               2: b = "G";
               3: b = "T";
               default: b = "N";
            endcase
         end
         BODY_QUAL: b = 8'($urandom_range(126, 33));
         default: begin
            do b = 8'($urandom_range(255)); while (b == CH_LF);
         end
      endcase
      return b;
   endfunction

   function automatic void line_break();
      if ($urandom_range(2) == 0) feed(KIND_DATA, CH_CR);
      feed(KIND_DATA, CH_LF);
   endfunction

   function automatic void add_header_line();
      feed(KIND_DATA, CH_AT);
      repeat ($urandom_range(5)) feed(KIND_DATA, body_byte(BODY_ANY));
      if ($urandom_range(1) == 1) begin
         feed(KIND_DATA, CH_SPACE);
         repeat ($urandom_range(4)) feed(KIND_DATA, body_byte(BODY_ANY));
      end
      line_break();
   endfunction

   function automatic void add_seq_line();
      int flavor;
      flavor = ($urandom_range(3) == 0) ? BODY_ANY : BODY_BASE;
      repeat ($urandom_range(8)) feed(KIND_DATA, body_byte(flavor));
      line_break();
   endfunction

   function automatic void add_sep_line();
      feed(KIND_DATA, CH_PLUS);
      if ($urandom_range(1) == 1)
         repeat ($urandom_range(6, 1)) feed(KIND_DATA, body_byte(BODY_ANY));
      line_break();
   endfunction

   function automatic void add_qual_line();
      repeat ($urandom_range(8)) feed(KIND_DATA, body_byte(BODY_QUAL));
      line_break();
   endfunction

   function automatic logic [7:0] byte_except(logic [7:0] a, logic [7:0] c);
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == a || b == c || b == CH_LF);
      return b;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            parse_step(req_kind, req_data_byte);
            items_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (feed_q.size() != 0 && $urandom_range(99) >= send_idle) begin
               next_item = feed_q.pop_front();
               req_valid <= 1'b1;
               req_kind <= next_item.kind;
               req_data_byte <= next_item.data;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.value = rsp_byte_value;
            got.valid = rsp_byte_valid;
            got.field = rsp_field_code;
            got.rec_done = rsp_record_done;
            got.strm_done = rsp_stream_done;
            got.err = rsp_error_code;
            got.last = rsp_last_of_run;
            beats_checked++;
            if (rsp_record_done) records_seen++;
            if (expected_beats.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result beat, expected none, actual %p", $time, got);
            end else begin
               want = expected_beats.pop_front();
               if (got.value !== want.value || got.valid !== want.valid ||
                   got.field !== want.field || got.rec_done !== want.rec_done ||
                   got.strm_done !== want.strm_done || got.err !== want.err ||
                   got.last !== want.last) begin
                  mismatches++;
                  $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("%0t: timeout, %0d beats still expected", $time, expected_beats.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      logic [7:0] directed[24];
      directed = '{CH_AT, 8'h00, 8'hFF, CH_SPACE, "c", CH_CR, CH_LF,
                   CH_CR, "G", CH_LF,
                   CH_PLUS, "z", CH_CR, CH_CR, CH_LF,
                   8'h21, 8'h7E, CH_LF,
                   CH_AT, CH_LF, CH_LF, CH_PLUS, CH_LF, CH_LF};
      foreach (directed[i]) feed(KIND_DATA, directed[i]);

      while (feed_q.size() < 24 + RANDOM_ITEMS) begin
         add_header_line();
         add_seq_line();
         add_sep_line();
         add_qual_line();
      end

      // the block halts for good on any ending, so one is picked per run
      end_kind = stream_end_type'($urandom_range(6));
      case (end_kind)
         END_CLEAN: feed(KIND_EOS, 8'($urandom_range(255)));
         END_IN_QUAL: begin
            add_header_line();
            add_seq_line();
            add_sep_line();
            if ($urandom_range(1) == 0) begin
               feed(KIND_DATA, CH_CR);
            end else begin
               repeat ($urandom_range(4, 1)) feed(KIND_DATA, body_byte(BODY_QUAL));
               if ($urandom_range(1) == 0) feed(KIND_DATA, CH_CR);
            end
            feed(KIND_EOS, 8'($urandom_range(255)));
         end
         END_TRUNCATED: begin
            case ($urandom_range(3))
               0: feed(KIND_DATA, CH_CR);
               1: begin
                  feed(KIND_DATA, CH_AT);
                  repeat ($urandom_range(3)) feed(KIND_DATA, body_byte(BODY_ANY));
               end
               2: begin
                  add_header_line();
                  add_seq_line();
               end
               default: begin
                  add_header_line();
                  add_seq_line();
                  feed(KIND_DATA, CH_PLUS);
                  repeat ($urandom_range(2)) feed(KIND_DATA, body_byte(BODY_ANY));
               end
            endcase
            feed(KIND_EOS, 8'($urandom_range(255)));
         end
         END_BAD_HEADER: feed(KIND_DATA, byte_except(CH_AT, CH_CR));
         END_EMPTY_HEADER: line_break();
         END_BAD_SEPARATOR: begin
            add_header_line();
            add_seq_line();
            feed(KIND_DATA, byte_except(CH_PLUS, CH_CR));
            line_break();
         end
         default: begin
            add_header_line();
            add_seq_line();
            line_break();
         end
      endcase
      // anything after the block stops must be ignored
      repeat (6) feed(1'($urandom_range(1)), 8'($urandom_range(255)));
      total_items = feed_q.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (items_accepted < total_items / 3) @(posedge clock);
      send_idle = 51;
      recv_idle = 38;
      while (items_accepted < 2 * total_items / 3) @(posedge clock);
      send_idle = 0;
      recv_idle = 0;
      while (items_accepted < total_items) @(posedge clock);
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("%0d input beats sent, %0d result beats checked, %0d records completed",
               total_items, beats_checked, records_seen);
      $display("stream ending exercised: %s", end_kind.name());
      if (mismatches == 0 && expected_beats.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
